[hw/rtl/dfir_pkg.sv]
// Shared types, constants and register codes for the decimating FIR filter.
`timescale 1ns / 1ps

package dfir_pkg;

    localparam int DFLT_MAX_TAPS     = 64;
    localparam int DFLT_SAMPLE_WIDTH = 16;

    localparam int TAP_W        = 16;
    localparam int TAP_IDX_W    = 6;
    localparam int TAP_COUNT_W  = 7;
    localparam int DECIM_W      = 5;
    localparam int SHIFT_W      = 5;
    localparam int PHASE_W      = 4;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int MAX_DECIMATION = 16;

    localparam logic [TAP_COUNT_W-1:0] RST_TAP_COUNT  = 7'd1;
    localparam logic [DECIM_W-1:0]     RST_DECIMATION = 5'd1;
    localparam logic [SHIFT_W-1:0]     RST_OUT_SHIFT  = 5'd15;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    typedef enum logic [1:0] {
        REG_TAP_COUNT  = 2'd0,
        REG_DECIMATION = 2'd1,
        REG_OUT_SHIFT  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [TAP_COUNT_W-1:0] tap_count;
        logic [DECIM_W-1:0]     decimation;
        logic [SHIFT_W-1:0]     out_shift;
    } t_cfg;

    typedef struct packed {
        logic clr;
        logic tap_wr;
        logic smp_wr;
        logic mac_start;
        logic issue;
        logic shift;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic pipe_busy;
    } t_dp_status;

endpackage

[hw/rtl/dfir_dp.sv]
// Datapath: tap and delay-line memories, shared MAC, shift, saturation, output register.
`timescale 1ns / 1ps

module dfir_dp #(
    parameter int MAX_TAPS     = dfir_pkg::DFLT_MAX_TAPS,
    parameter int SAMPLE_WIDTH = dfir_pkg::DFLT_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dfir_pkg::t_dp_cmd                   i_cmd,
    input  logic [dfir_pkg::SHIFT_W-1:0]        i_out_shift,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_in,
    input  logic [dfir_pkg::TAP_IDX_W-1:0]      i_tap_index,
    input  logic signed [dfir_pkg::TAP_W-1:0]   i_tap_value,
    output dfir_pkg::t_dp_status                o_status,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic                                o_saturated
);
    import dfir_pkg::*;

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int PW    = TAP_W + SAMPLE_WIDTH;
    localparam int ACC_W = PW + AW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic signed [TAP_W-1:0]        tap_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] dly_mem [MAX_TAPS];

    logic [AW-1:0]                  r_clr_addr;
    logic [AW-1:0]                  r_line_pos;
    logic [AW-1:0]                  r_k;
    logic [AW-1:0]                  r_p;
    logic                           r_v1;
    logic                           r_v2;
    logic signed [TAP_W-1:0]        r_tap_q;
    logic signed [SAMPLE_WIDTH-1:0] r_smp_q;
    logic signed [PW-1:0]           r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [ACC_W-1:0]        r_shifted;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_sat;

    logic [AW-1:0] next_pos;
    logic [31:0]   idx_ext;
    logic [AW-1:0] wr_addr;
    logic          idx_ok;
    logic signed [SAMPLE_WIDTH-1:0] sat_value;
    logic                           sat_flag;

    assign next_pos = (r_line_pos == LAST_ADDR) ? '0 : r_line_pos + AW'(1);
    assign idx_ext  = 32'(i_tap_index);
    assign wr_addr  = idx_ext[AW-1:0];
    assign idx_ok   = (idx_ext < 32'(MAX_TAPS));

    // Coefficient store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            tap_mem[r_clr_addr] <= '0;
        end else if (i_cmd.tap_wr && idx_ok) begin
            tap_mem[wr_addr] <= i_tap_value;
        end
        if (i_cmd.issue) begin
            r_tap_q <= tap_mem[r_k];
        end
    end

    // Delay line, circular with the newest sample at r_line_pos
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            dly_mem[r_clr_addr] <= '0;
        end else if (i_cmd.smp_wr) begin
            dly_mem[next_pos] <= i_sample_in;
        end
        if (i_cmd.issue) begin
            r_smp_q <= dly_mem[r_p];
        end
    end

    // Control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_line_pos <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.smp_wr) begin
                r_line_pos <= next_pos;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_start) begin
            r_k   <= '0;
            r_p   <= next_pos;
            r_acc <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_k <= r_k + AW'(1);
                r_p <= (r_p == '0) ? LAST_ADDR : r_p - AW'(1);
            end
            if (r_v2) begin
                r_acc <= r_acc + {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};
            end
        end
        if (r_v1) begin
            r_prod <= r_tap_q * r_smp_q;
        end
        if (i_cmd.shift) begin
            r_shifted <= r_acc >>> i_out_shift;
        end
        if (i_cmd.load_out) begin
            r_out_sample <= sat_value;
            r_out_sat    <= sat_flag;
        end
    end

    always_comb begin
        if (r_shifted > SAT_HI) begin
            sat_value = SAT_HI[SAMPLE_WIDTH-1:0];
            sat_flag  = 1'b1;
        end else if (r_shifted < SAT_LO) begin
            sat_value = SAT_LO[SAMPLE_WIDTH-1:0];
            sat_flag  = 1'b1;
        end else begin
            sat_value = r_shifted[SAMPLE_WIDTH-1:0];
            sat_flag  = 1'b0;
        end
    end

    assign o_status.clr_last  = (r_clr_addr == LAST_ADDR);
    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_sample_out       = r_out_sample;
    assign o_saturated        = r_out_sat;

endmodule

[hw/rtl/dfir_ctrl.sv]
// Controller: clear pass, decimation phase, tap sequencing and output handshake.
`timescale 1ns / 1ps

module dfir_ctrl #(
    parameter int MAX_TAPS = dfir_pkg::DFLT_MAX_TAPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dfir_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    input  logic                 i_kind,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  dfir_pkg::t_dp_status i_status,
    output dfir_pkg::t_dp_cmd    o_cmd
);
    import dfir_pkg::*;

    localparam int CW = $clog2(MAX_TAPS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;

    logic [31:0]          tc_int;
    logic [CW-1:0]        ntaps;
    logic [DECIM_W-1:0]   dec;
    logic [DECIM_W-1:0]   phase_inc;

    always_comb begin
        tc_int = 32'(i_cfg.tap_count);
        if (tc_int == 32'd0) begin
            tc_int = 32'd1;
        end else if (tc_int > 32'(MAX_TAPS)) begin
            tc_int = 32'(MAX_TAPS);
        end
        ntaps = CW'(tc_int);
    end

    always_comb begin
        if (i_cfg.decimation == '0) begin
            dec = DECIM_W'(1);
        end else if (32'(i_cfg.decimation) > MAX_DECIMATION) begin
            dec = DECIM_W'(MAX_DECIMATION);
        end else begin
            dec = i_cfg.decimation;
        end
    end

    assign phase_inc = {1'b0, r_phase} + DECIM_W'(1);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_TAP) begin
                        o_cmd.tap_wr = 1'b1;
                    end else begin
                        o_cmd.smp_wr = 1'b1;
                        if (phase_inc < dec) begin
                            n_phase = r_phase + PHASE_W'(1);
                        end else begin
                            n_phase         = '0;
                            n_cnt           = '0;
                            o_cmd.mac_start = 1'b1;
                            n_state         = S_MAC;
                        end
                    end
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                n_cnt       = r_cnt + CW'(1);
                if (r_cnt == ntaps - CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && i_out_stall) || o_cmd.load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_cnt < ntaps))
        else $error("tap counter ran past tap count");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while holding a result");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_status.pipe_busy)
        else $error("MAC pipeline busy while idle");

    a_phase_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mac_start |=> (r_phase == '0 && r_state == S_MAC))
        else $error("result sample did not restart decimation phase");

endmodule

[hw/rtl/decimating_fir_filter_unit.sv]
// Top level: APB register file, controller and datapath of the decimating FIR.
`timescale 1ns / 1ps

// Real direct-form FIR with decimation, one shared multiply-accumulate. Tap writes
// (kind 1) and samples that produce no result are taken without stalling the input.
// A sample that produces a result keeps the input stalled while the single MAC
// steps through the taps (coefficient and delay-line memories read one entry per
// cycle), while the pipeline drains and the sum is shifted, and while it is
// saturated into the output register. That last step waits as long as the output
// register still holds an earlier result that has not been taken. The finished
// result waits in that register, so the next item is taken while it is still
// pending. After reset a clearing pass zeroes both memories, during which no item
// is taken; register writes are taken at any time. Registers: tap_count at 0x0,
// decimation at 0x4, out_shift at 0x8.
module decimating_fir_filter_unit #(
    parameter int MAX_TAPS     = dfir_pkg::DFLT_MAX_TAPS,
    parameter int SAMPLE_WIDTH = dfir_pkg::DFLT_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dfir_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dfir_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dfir_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_in,
    input  logic [dfir_pkg::TAP_IDX_W-1:0]      i_tap_index,
    input  logic signed [dfir_pkg::TAP_W-1:0]   i_tap_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic                                o_saturated
);
    import dfir_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   reg_idx;
    logic       apb_wr;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign apb_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_count  <= RST_TAP_COUNT;
            r_cfg.decimation <= RST_DECIMATION;
            r_cfg.out_shift  <= RST_OUT_SHIFT;
        end else if (apb_wr) begin
            case (reg_idx)
                REG_TAP_COUNT:  r_cfg.tap_count  <= pwdata[TAP_COUNT_W-1:0];
                REG_DECIMATION: r_cfg.decimation <= pwdata[DECIM_W-1:0];
                REG_OUT_SHIFT:  r_cfg.out_shift  <= pwdata[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TAP_COUNT:  prdata = APB_DATA_W'(r_cfg.tap_count);
            REG_DECIMATION: prdata = APB_DATA_W'(r_cfg.decimation);
            REG_OUT_SHIFT:  prdata = APB_DATA_W'(r_cfg.out_shift);
            default:        prdata = '0;
        endcase
    end

    dfir_ctrl #(
        .MAX_TAPS(MAX_TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dfir_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_out_shift (r_cfg.out_shift),
        .i_sample_in (i_sample_in),
        .i_tap_index (i_tap_index),
        .i_tap_value (i_tap_value),
        .o_status    (status),
        .o_sample_out(o_sample_out),
        .o_saturated (o_saturated)
    );

endmodule
